@@ rtl/ptm_pkg.sv @@
// ---------------------------------------------------------------------------
// ptm_pkg: shared definitions for the point-in-triangle mesh test
// Default sizes, register indexes, datapath operation codes and the command
// bundle that the controller sends to the datapath.
// ---------------------------------------------------------------------------
package ptm_pkg;

   localparam int MAX_TRIANGLES_DEF = 256;
   localparam int COORD_BITS_DEF    = 16;
   localparam int CORNERS_PER_TRI   = 3;
   localparam int SCALE_FRAC_BITS   = 8;
   localparam int SCALE_BITS        = 16;
   localparam int COUNT_BITS        = 9;
   localparam int SLOT_BITS         = 10;
   localparam int HIT_BITS          = 8;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd1280;

   // Configuration register indexes.
   localparam logic CSR_TRI_COUNT = 1'b0;
   localparam logic CSR_SCALE     = 1'b1;

   // Query modes.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Datapath operations.
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_SCALE = 3'd1;
   localparam logic [2:0] OP_DIFF  = 3'd2;
   localparam logic [2:0] OP_CROSS = 3'd3;
   localparam logic [2:0] OP_DOT   = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] corner;
      logic [3:0] step;
      logic [1:0] edge_sel;
      logic       pt_load;
      logic       ram_re;
      logic       ram_we;
   } ptm_cmd_type;

endpackage

@@ rtl/ptm_ram.sv @@
// ---------------------------------------------------------------------------
// ptm_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data updates only on a read.
// ---------------------------------------------------------------------------
module ptm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/ptm_datapath.sv @@
// ---------------------------------------------------------------------------
// ptm_datapath: corner store, scaling and same-side arithmetic
// One shared signed multiplier feeds an exact accumulator. The controller
// steps it through scaling, edge differences, cross products and the dot
// product whose sign decides one edge test.
// ---------------------------------------------------------------------------
module ptm_datapath
   import ptm_pkg::*;
#(
   parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
   parameter int COORD_BITS    = COORD_BITS_DEF
) (
   input  logic                                        clock,
   input  ptm_cmd_type                                 cmd,
   input  logic [$clog2(CORNERS_PER_TRI*MAX_TRIANGLES)-1:0] ram_addr,
   input  logic [SCALE_BITS-1:0]                       coord_scale,
   input  logic signed [COORD_BITS-1:0]                coord_x,
   input  logic signed [COORD_BITS-1:0]                coord_y,
   input  logic signed [COORD_BITS-1:0]                coord_z,
   output logic                                        dot_neg
);

   localparam int W     = COORD_BITS;
   localparam int DEPTH = CORNERS_PER_TRI * MAX_TRIANGLES;
   localparam int DW    = W + 1;
   localparam int CW    = 2 * W + 3;
   localparam int BW    = W + 2;
   localparam int PW    = CW + BW;
   localparam int ACW   = 2 * CW + 2;
   localparam int SPLIT = W + 1;

   localparam logic signed [ACW-1:0] SAT_HI = ACW'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [ACW-1:0] SAT_LO = -SAT_HI - ACW'(1);

   logic [3*W-1:0] rd_word;

   ptm_ram #(
      .WIDTH(3 * W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (cmd.ram_we),
      .waddr(ram_addr),
      .wdata({coord_z, coord_y, coord_x}),
      .re   (cmd.ram_re),
      .raddr(ram_addr),
      .rdata(rd_word)
   );

   logic signed [W-1:0]   pt_ff [3];
   logic signed [W-1:0]   sc_ff [3][3];
   logic signed [DW-1:0]  e_ff  [3];
   logic signed [DW-1:0]  d1_ff [3];
   logic signed [DW-1:0]  d2_ff [3];
   logic signed [CW-1:0]  c1_ff [3];
   logic signed [CW-1:0]  c2_ff [3];
   logic signed [ACW-1:0] acc_ff;
   logic                  neg_ff;

   logic signed [CW-1:0]  mul_a;
   logic signed [BW-1:0]  mul_b;
   logic signed [PW-1:0]  prod;
   logic signed [ACW-1:0] term;
   logic signed [ACW-1:0] acc_in;
   logic signed [ACW-1:0] scaled;
   logic signed [W-1:0]   sat_val;
   logic                  clr;
   logic                  sub;
   logic                  shift;
   logic                  c_store;
   logic [1:0]            c_idx;
   logic signed [W-1:0]   pa [3];
   logic signed [W-1:0]   pb [3];
   logic signed [W-1:0]   pp [3];
   logic signed [DW-1:0]  v  [3];
   logic [3:0]            m;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      clr     = 1'b0;
      sub     = 1'b0;
      shift   = 1'b0;
      c_store = 1'b0;
      c_idx   = 2'd0;
      m       = (cmd.step >= 4'd6) ? cmd.step - 4'd6 : cmd.step;
      for (int k = 0; k < 3; k++) begin
         v[k] = (cmd.step >= 4'd6) ? d2_ff[k] : d1_ff[k];
      end
      case (cmd.op)
         OP_SCALE: begin
            mul_a = CW'($signed({1'b0, coord_scale}));
            mul_b = BW'($signed(rd_word[cmd.step[1:0]*W +: W]));
            clr   = 1'b1;
         end
         OP_CROSS: begin
            case (m)
               4'd0: begin
                  mul_a = CW'(e_ff[1]); mul_b = BW'(v[2]); clr = 1'b1;
               end
               4'd1: begin
                  mul_a = CW'(e_ff[2]); mul_b = BW'(v[1]); sub = 1'b1;
                  c_store = 1'b1; c_idx = 2'd0;
               end
               4'd2: begin
                  mul_a = CW'(e_ff[2]); mul_b = BW'(v[0]); clr = 1'b1;
               end
               4'd3: begin
                  mul_a = CW'(e_ff[0]); mul_b = BW'(v[2]); sub = 1'b1;
                  c_store = 1'b1; c_idx = 2'd1;
               end
               4'd4: begin
                  mul_a = CW'(e_ff[0]); mul_b = BW'(v[1]); clr = 1'b1;
               end
               default: begin
                  mul_a = CW'(e_ff[1]); mul_b = BW'(v[0]); sub = 1'b1;
                  c_store = 1'b1; c_idx = 2'd2;
               end
            endcase
         end
         OP_DOT: begin
            // c2 is split into a signed high part and an unsigned low part.
            case (cmd.step)
               4'd0: begin
                  mul_a = c1_ff[0]; mul_b = c2_ff[0][CW-1:SPLIT];
                  shift = 1'b1; clr = 1'b1;
               end
               4'd1: begin
                  mul_a = c1_ff[0]; mul_b = $signed({1'b0, c2_ff[0][SPLIT-1:0]});
               end
               4'd2: begin
                  mul_a = c1_ff[1]; mul_b = c2_ff[1][CW-1:SPLIT]; shift = 1'b1;
               end
               4'd3: begin
                  mul_a = c1_ff[1]; mul_b = $signed({1'b0, c2_ff[1][SPLIT-1:0]});
               end
               4'd4: begin
                  mul_a = c1_ff[2]; mul_b = c2_ff[2][CW-1:SPLIT]; shift = 1'b1;
               end
               default: begin
                  mul_a = c1_ff[2]; mul_b = $signed({1'b0, c2_ff[2][SPLIT-1:0]});
               end
            endcase
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign prod   = PW'(mul_a) * PW'(mul_b);
   assign term   = shift ? (ACW'(prod) <<< SPLIT) : ACW'(prod);
   assign acc_in = sub ? ((clr ? '0 : acc_ff) - term) : ((clr ? '0 : acc_ff) + term);
   assign scaled = acc_in >>> SCALE_FRAC_BITS;

   always_comb begin
      if (scaled > SAT_HI) begin
         sat_val = SAT_HI[W-1:0];
      end else if (scaled < SAT_LO) begin
         sat_val = SAT_LO[W-1:0];
      end else begin
         sat_val = scaled[W-1:0];
      end
   end

   // Corners of the current edge test: line from pa to pb, opposite corner pp.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         case (cmd.edge_sel)
            2'd0: begin
               pa[k] = sc_ff[1][k]; pb[k] = sc_ff[2][k]; pp[k] = sc_ff[0][k];
            end
            2'd1: begin
               pa[k] = sc_ff[0][k]; pb[k] = sc_ff[2][k]; pp[k] = sc_ff[1][k];
            end
            default: begin
               pa[k] = sc_ff[0][k]; pb[k] = sc_ff[1][k]; pp[k] = sc_ff[2][k];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pt_load) begin
         pt_ff[0] <= coord_x;
         pt_ff[1] <= coord_y;
         pt_ff[2] <= coord_z;
      end
      if (cmd.op != OP_NONE && cmd.op != OP_DIFF) begin
         acc_ff <= acc_in;
      end
      if (cmd.op == OP_SCALE) begin
         sc_ff[cmd.corner][cmd.step[1:0]] <= sat_val;
      end
      if (cmd.op == OP_DIFF) begin
         for (int k = 0; k < 3; k++) begin
            e_ff[k]  <= DW'(pb[k]) - DW'(pa[k]);
            d1_ff[k] <= DW'(pt_ff[k]) - DW'(pa[k]);
            d2_ff[k] <= DW'(pp[k]) - DW'(pa[k]);
         end
      end
      if (cmd.op == OP_CROSS && c_store) begin
         if (cmd.step >= 4'd6) begin
            c2_ff[c_idx] <= acc_in[CW-1:0];
         end else begin
            c1_ff[c_idx] <= acc_in[CW-1:0];
         end
      end
      if (cmd.op == OP_DOT && cmd.step == 4'd5) begin
         neg_ff <= acc_in[ACW-1];
      end
   end

   assign dot_neg = neg_ff;

endmodule

@@ rtl/ptm_ctrl.sv @@
// ---------------------------------------------------------------------------
// ptm_ctrl: sequencer for loads and triangle walks
// Accepts items, steps the datapath through each triangle and edge, and
// holds the result register.
// ---------------------------------------------------------------------------
module ptm_ctrl
   import ptm_pkg::*;
#(
   parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_valid,
   output logic                                             req_stall,
   input  logic                                             req_mode,
   input  logic [SLOT_BITS-1:0]                             req_corner_slot,
   input  logic [COUNT_BITS-1:0]                            triangle_count,
   output logic                                             rsp_valid,
   input  logic                                             rsp_stall,
   output logic                                             rsp_inside_res,
   output logic [HIT_BITS-1:0]                              rsp_hit_triangle,
   output ptm_cmd_type                                      cmd,
   output logic [$clog2(CORNERS_PER_TRI*MAX_TRIANGLES)-1:0] ram_addr,
   input  logic                                             dot_neg
);

   localparam int DEPTH = CORNERS_PER_TRI * MAX_TRIANGLES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNTW  = ($clog2(MAX_TRIANGLES + 1) > COUNT_BITS) ?
                          $clog2(MAX_TRIANGLES + 1) : COUNT_BITS;
   localparam int SLW   = (AW + 1 > SLOT_BITS) ? AW + 1 : SLOT_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_SCL  = 3'd2;
   localparam logic [2:0] ST_DIFF = 3'd3;
   localparam logic [2:0] ST_CRS  = 3'd4;
   localparam logic [2:0] ST_DOT  = 3'd5;
   localparam logic [2:0] ST_CHK  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CNTW-1:0]     tri_ff, tri_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [1:0]          cor_ff, cor_in;
   logic [3:0]          step_ff, step_in;
   logic [1:0]          edge_ff, edge_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_inside_ff, rsp_inside_in;
   logic [HIT_BITS-1:0] rsp_hit_ff, rsp_hit_in;
   logic                accept;
   logic                slot_ok;
   logic [CNTW-1:0]     cnt_req;
   logic [AW+1:0]       rd_addr;

   assign req_stall = !(state_ff == ST_IDLE && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign slot_ok   = SLW'(req_corner_slot) < SLW'(DEPTH);
   assign cnt_req   = (CNTW'(triangle_count) > CNTW'(MAX_TRIANGLES)) ?
                      CNTW'(MAX_TRIANGLES) : CNTW'(triangle_count);
   assign rd_addr   = (AW + 2)'(tri_ff) * (AW + 2)'(CORNERS_PER_TRI) + (AW + 2)'(cor_ff);
   assign ram_addr  = (state_ff == ST_IDLE) ? AW'(req_corner_slot) : rd_addr[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      tri_in        = tri_ff;
      cnt_in        = cnt_ff;
      cor_in        = cor_ff;
      step_in       = step_ff;
      edge_in       = edge_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_inside_in = rsp_inside_ff;
      rsp_hit_in    = rsp_hit_ff;
      cmd           = '0;
      cmd.op        = OP_NONE;
      cmd.corner    = cor_ff;
      cmd.step      = step_ff;
      cmd.edge_sel  = edge_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_LOAD) begin
                  cmd.ram_we    = slot_ok;
                  rsp_valid_in  = 1'b1;
                  rsp_inside_in = 1'b0;
                  rsp_hit_in    = '0;
               end else begin
                  cmd.pt_load = 1'b1;
                  cnt_in      = cnt_req;
                  tri_in      = '0;
                  cor_in      = 2'd0;
                  if (cnt_req == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_inside_in = 1'b0;
                     rsp_hit_in    = '0;
                  end else begin
                     state_in = ST_RD;
                  end
               end
            end
         end
         ST_RD: begin
            cmd.ram_re = 1'b1;
            step_in    = 4'd0;
            state_in   = ST_SCL;
         end
         ST_SCL: begin
            cmd.op = OP_SCALE;
            if (step_ff == 4'd2) begin
               if (cor_ff == 2'd2) begin
                  edge_in  = 2'd0;
                  state_in = ST_DIFF;
               end else begin
                  cor_in   = cor_ff + 2'd1;
                  state_in = ST_RD;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            step_in  = 4'd0;
            state_in = ST_CRS;
         end
         ST_CRS: begin
            cmd.op = OP_CROSS;
            if (step_ff == 4'd11) begin
               step_in  = 4'd0;
               state_in = ST_DOT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_DOT: begin
            cmd.op = OP_DOT;
            if (step_ff == 4'd5) begin
               state_in = ST_CHK;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_CHK: begin
            if (dot_neg) begin
               if (tri_ff + CNTW'(1) == cnt_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_inside_in = 1'b0;
                  rsp_hit_in    = '0;
                  state_in      = ST_IDLE;
               end else begin
                  tri_in   = tri_ff + CNTW'(1);
                  cor_in   = 2'd0;
                  state_in = ST_RD;
               end
            end else if (edge_ff == 2'd2) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = 1'b1;
               rsp_hit_in    = tri_ff[HIT_BITS-1:0];
               state_in      = ST_IDLE;
            end else begin
               edge_in  = edge_ff + 2'd1;
               state_in = ST_DIFF;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tri_ff        <= tri_in;
      cnt_ff        <= cnt_in;
      cor_ff        <= cor_in;
      step_ff       <= step_in;
      edge_ff       <= edge_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = rsp_inside_ff;
   assign rsp_hit_triangle = rsp_hit_ff;

endmodule

@@ rtl/point_in_triangle_mesh_test.sv @@
// ---------------------------------------------------------------------------
// point_in_triangle_mesh_test: same-side point test over a stored mesh
// Top level: configuration registers, sequencer and arithmetic datapath.
// ---------------------------------------------------------------------------
// A load item (mode 0) writes one triangle corner into the corner store and
// returns a zero result in the next cycle; a slot beyond the store is dropped.
// Loads can be accepted one per cycle while the result is not stalled. A query
// item (mode 1) walks the first triangle_count triangles (capped at
// MAX_TRIANGLES), scaling each stored corner by coord_scale and testing the
// point against the edges with the same-side rule. The walk stops at the
// first containing triangle. Each corner of a triangle takes one store read
// and three scaling steps, and each edge tested takes one difference step,
// 12 cross product steps, 6 dot product steps and one check; the scaling,
// cross and dot product steps share a single signed multiplier. No new item
// is accepted until the walk ends and the result is registered; the shared
// multiplier sets this. A query with a zero count answers in the next cycle,
// like a load. The corner store holds no meaningful data after reset, so a
// query must only visit triangles whose corners were loaded.
// Configuration may be written only while the block is idle.
// ---------------------------------------------------------------------------
module point_in_triangle_mesh_test
   import ptm_pkg::*;
#(
   parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
   parameter int COORD_BITS    = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_mode,
   input  logic [SLOT_BITS-1:0]         req_corner_slot,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_BITS-1:0] req_coord_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_inside_res,
   output logic [HIT_BITS-1:0]          rsp_hit_triangle,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [SCALE_BITS-1:0]        csr_wdata
);

   localparam int AW = $clog2(CORNERS_PER_TRI * MAX_TRIANGLES);

   logic [COUNT_BITS-1:0] tri_count_ff;
   logic [SCALE_BITS-1:0] scale_ff;
   ptm_cmd_type           cmd;
   logic [AW-1:0]         ram_addr;
   logic                  dot_neg;

   // Registers accept a write in every cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tri_count_ff <= '0;
         scale_ff     <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TRI_COUNT) begin
            tri_count_ff <= csr_wdata[COUNT_BITS-1:0];
         end else begin
            scale_ff <= csr_wdata;
         end
      end
   end

   ptm_ctrl #(
      .MAX_TRIANGLES(MAX_TRIANGLES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_corner_slot (req_corner_slot),
      .triangle_count  (tri_count_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_hit_triangle(rsp_hit_triangle),
      .cmd             (cmd),
      .ram_addr        (ram_addr),
      .dot_neg         (dot_neg)
   );

   ptm_datapath #(
      .MAX_TRIANGLES(MAX_TRIANGLES),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .ram_addr   (ram_addr),
      .coord_scale(scale_ff),
      .coord_x    (req_coord_x),
      .coord_y    (req_coord_y),
      .coord_z    (req_coord_z),
      .dot_neg    (dot_neg)
   );

endmodule

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench for point_in_triangle_mesh_test
// Fills the corner store, runs directed mesh queries and a long hold-off on
// the result side, then random loads and queries under changing scale and
// triangle counts. Every result is checked against an in-bench predictor.
// ---------------------------------------------------------------------------
module tb_top;
   import ptm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS   = CORNERS_PER_TRI * MAX_TRIANGLES_DEF;
   localparam int CYCLE_LIMIT = 3_000_000;

   typedef logic signed [COORD_BITS_DEF-1:0] coord_type;
   typedef logic signed [127:0] wide_type;
   typedef longint vec3_type [3];

   typedef struct {
      logic                in_mesh;
      logic [HIT_BITS-1:0] hit;
   } mesh_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_mode;
   logic [SLOT_BITS-1:0]    req_corner_slot;
   coord_type               req_coord_x;
   coord_type               req_coord_y;
   coord_type               req_coord_z;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_inside_res;
   logic [HIT_BITS-1:0]     rsp_hit_triangle;
   logic                    csr_valid;
   logic                    csr_ready;
   logic                    csr_index;
   logic [SCALE_BITS-1:0]   csr_wdata;

   point_in_triangle_mesh_test i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_corner_slot  (req_corner_slot),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_hit_triangle (rsp_hit_triangle),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Shadow of the block's state: the corner store and both registers.
   coord_type           mesh_corners [NUM_SLOTS][3];
   logic [COUNT_BITS-1:0] tri_count_cfg;
   logic [SCALE_BITS-1:0] scale_cfg;

   mesh_result_type     pending_results [$];
   int                  error_count;
   int                  load_items;
   int                  query_items;
   int                  hit_count;
   int                  checked_count;
   bit                  idling_on;
   int                  long_hold_len;
   int                  hold_count;
   int                  stall_burst;
   longint              cycle_count;

   // Clock generator.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // Result-side stall. A long hold-off requested by the stimulus takes
   // priority over the random bursts.
   always @(posedge clock) begin
      if (long_hold_len != 0) begin
         hold_count    = long_hold_len;
         long_hold_len = 0;
      end
      if (hold_count > 0) begin
         rsp_stall  <= 1'b1;
         hold_count = hold_count - 1;
      end else if (stall_burst > 0) begin
         rsp_stall   <= 1'b1;
         stall_burst = stall_burst - 1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall   <= 1'b1;
         stall_burst = $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Scale one stored coordinate: floor(c * scale / 256), saturated.
   function automatic longint scaled_coord(coord_type c);
      longint prod;
      longint q;
      prod = longint'(c) * longint'(scale_cfg);
      q    = prod >>> SCALE_FRAC_BITS;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   function automatic void scaled_corner(int slot, output vec3_type v);
      for (int k = 0; k < 3; k++) v[k] = scaled_coord(mesh_corners[slot][k]);
   endfunction

   // True if p1 and p2 lie on the same side of line a-b, boundary included.
   // Cross products stay within 40 bits; only the dot product needs more.
   function automatic bit on_same_side(vec3_type p1, vec3_type p2, vec3_type a,
                                       vec3_type b);
      longint   e [3];
      longint   d1 [3];
      longint   d2 [3];
      longint   c1 [3];
      longint   c2 [3];
      wide_type dot;
      for (int k = 0; k < 3; k++) begin
         e[k]  = b[k] - a[k];
         d1[k] = p1[k] - a[k];
         d2[k] = p2[k] - a[k];
      end
      c1[0] = e[1] * d1[2] - e[2] * d1[1];
      c1[1] = e[2] * d1[0] - e[0] * d1[2];
      c1[2] = e[0] * d1[1] - e[1] * d1[0];
      c2[0] = e[1] * d2[2] - e[2] * d2[1];
      c2[1] = e[2] * d2[0] - e[0] * d2[2];
      c2[2] = e[0] * d2[1] - e[1] * d2[0];
      dot = wide_type'(c1[0]) * wide_type'(c2[0]) + wide_type'(c1[1]) * wide_type'(c2[1])
          + wide_type'(c1[2]) * wide_type'(c2[2]);
      return dot >= 0;
   endfunction

   // Walk the mesh for one query point and return the first containing triangle.
   function automatic mesh_result_type predict_query(coord_type x, coord_type y,
                                                     coord_type z);
      mesh_result_type r;
      vec3_type        p;
      vec3_type        a;
      vec3_type        b;
      vec3_type        c;
      int              walk_len;
      r.in_mesh = 1'b0;
      r.hit     = '0;
      p[0] = x;
      p[1] = y;
      p[2] = z;
      walk_len = (tri_count_cfg > MAX_TRIANGLES_DEF) ? MAX_TRIANGLES_DEF : tri_count_cfg;
      for (int t = 0; t < walk_len; t++) begin
         scaled_corner(3 * t, a);
         scaled_corner(3 * t + 1, b);
         scaled_corner(3 * t + 2, c);
         if (on_same_side(p, a, b, c) && on_same_side(p, b, a, c) &&
             on_same_side(p, c, a, b)) begin
            r.in_mesh = 1'b1;
            r.hit     = t[HIT_BITS-1:0];
            break;
         end
      end
      return r;
   endfunction

   // Offer one item, wait for it to be taken, then record its expected result.
   // Valid is only lowered at the start of a gap, never at acceptance.
   task automatic send_item(logic mode, logic [SLOT_BITS-1:0] slot,
                            coord_type x, coord_type y, coord_type z);
      int              gap;
      mesh_result_type r;
      gap = 0;
      if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_corner_slot <= slot;
      req_coord_x     <= x;
      req_coord_y     <= y;
      req_coord_z     <= z;
      do @(posedge clock); while (req_stall);
      r.in_mesh = 1'b0;
      r.hit     = '0;
      if (mode == MODE_LOAD) begin
         load_items++;
         if (slot < NUM_SLOTS) begin
            mesh_corners[slot][0] = x;
            mesh_corners[slot][1] = y;
            mesh_corners[slot][2] = z;
         end
      end else begin
         query_items++;
         r = predict_query(x, y, z);
         if (r.in_mesh) hit_count++;
      end
      pending_results.insert(pending_results.size(), r);
   endtask

   task automatic query_point(coord_type x, coord_type y, coord_type z);
      send_item(MODE_QUERY, SLOT_BITS'($urandom_range(0, 1023)), x, y, z);
   endtask

   // Stop offering items and wait until every expected result has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Write both registers back to back; only legal while the block is idle.
   task automatic write_regs(int count, int scale);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_TRI_COUNT;
      csr_wdata <= SCALE_BITS'(count);
      do @(posedge clock); while (!csr_ready);
      tri_count_cfg = COUNT_BITS'(count);
      csr_index <= CSR_SCALE;
      csr_wdata <= SCALE_BITS'(scale);
      do @(posedge clock); while (!csr_ready);
      scale_cfg = SCALE_BITS'(scale);
      csr_valid <= 1'b0;
   endtask

   // Mostly moderate coordinates so that scaling keeps shapes, some extremes.
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return -16'sh8000;
         2, 3:    return coord_type'($urandom);
         default: return coord_type'(int'($urandom_range(0, 3000)) - 1500);
      endcase
   endfunction

   // A point near a stored triangle: one of its scaled corners or its centroid.
   task automatic query_near_triangle(int tri_idx);
      vec3_type a;
      vec3_type b;
      vec3_type c;
      scaled_corner(3 * tri_idx, a);
      scaled_corner(3 * tri_idx + 1, b);
      scaled_corner(3 * tri_idx + 2, c);
      if ($urandom_range(0, 1) == 0)
         query_point(coord_type'(a[0]), coord_type'(a[1]), coord_type'(a[2]));
      else
         query_point(coord_type'((a[0] + b[0] + c[0]) / 3),
                     coord_type'((a[1] + b[1] + c[1]) / 3),
                     coord_type'((a[2] + b[2] + c[2]) / 3));
   endtask

   // Result checker: every accepted result is compared with the oldest expectation.
   always @(posedge clock) begin
      mesh_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result inside_res=%0b hit_triangle=%0d",
                     $time, rsp_inside_res, rsp_hit_triangle);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            checked_count++;
            if (rsp_inside_res !== exp_r.in_mesh) begin
               $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                        $time, exp_r.in_mesh, rsp_inside_res);
               error_count++;
            end
            if (rsp_hit_triangle !== exp_r.hit) begin
               $display("%0t: hit_triangle mismatch, expected %0d, actual %0d",
                        $time, exp_r.hit, rsp_hit_triangle);
               error_count++;
            end
         end
      end
   end

   // Every slot is written once so that any later query only reads loaded corners.
   task automatic test_fill_store();
      write_regs(0, SCALE_RESET);
      for (int s = 0; s < NUM_SLOTS; s++)
         send_item(MODE_LOAD, SLOT_BITS'(s), rand_coord(), rand_coord(), rand_coord());
   endtask

   // Hand-built triangles: a unit triangle, one with extreme corners, a random
   // one and a zero-area one that catches every point that reaches it.
   task automatic test_directed_mesh();
      send_item(MODE_LOAD, 0, 0, 0, 0);
      send_item(MODE_LOAD, 1, 256, 0, 0);
      send_item(MODE_LOAD, 2, 0, 256, 0);
      send_item(MODE_LOAD, 3, 16'sh7FFF, 16'sh7FFF, -16'sh8000);
      send_item(MODE_LOAD, 4, -16'sh8000, 16'sh7FFF, 0);
      send_item(MODE_LOAD, 5, 0, -16'sh8000, 16'sh7FFF);
      for (int s = 9; s < 12; s++) send_item(MODE_LOAD, SLOT_BITS'(s), 100, -200, 300);
      write_regs(4, SCALE_RESET);
      query_point(427, 427, 0);                   // centroid of the unit triangle
      query_point(1280, 0, 0);                    // on a corner: boundary counts
      query_point(640, 640, 0);                   // on the hypotenuse
      query_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      query_point(-16'sh8000, -16'sh8000, -16'sh8000);
      // Out-of-range slots are dropped; the mesh must answer as before.
      send_item(MODE_LOAD, 768, 1, 2, 3);
      send_item(MODE_LOAD, 1023, -1, -2, -3);
      query_point(427, 427, 0);
      write_regs(3, SCALE_RESET);                 // zero-area triangle out of reach
      query_point(5000, 5000, 5000);
      query_point(-16'sh8000, 16'sh7FFF, 0);
      write_regs(0, SCALE_RESET);                 // empty walk reports a miss
      query_point(427, 427, 0);
      write_regs(511, 16'hFFFF);                  // count saturates to a full walk
      query_point(-16'sh8000, 16'sh7FFF, -16'sh8000);
      write_regs(256, 0);                         // zero scale: all triangles collapse
      query_point(1, -1, 1);
      write_regs(256, 256);
      query_point(rand_coord(), rand_coord(), rand_coord());
   endtask

   // The result side holds off while the sender keeps offering loads, so the
   // block fills up and has to stall its input.
   task automatic test_result_holdoff();
      write_regs(2, SCALE_RESET);
      idling_on     = 1'b0;
      long_hold_len = 300;
      for (int i = 0; i < 40; i++)
         send_item(MODE_LOAD, SLOT_BITS'($urandom_range(0, 1023)),
                   rand_coord(), rand_coord(), rand_coord());
      query_near_triangle(1);
      idling_on = 1'b1;
   endtask

   // Random phases with small walks; most queries aim at stored triangles.
   task automatic test_random_phases(int phases, int items_per_phase);
      int count;
      int scale;
      for (int ph = 0; ph < phases; ph++) begin
         count = $urandom_range(1, 8);
         case ($urandom_range(0, 4))
            0:       scale = 0;
            1:       scale = 256;
            2:       scale = SCALE_RESET;
            3:       scale = 16'hFFFF;
            default: scale = $urandom_range(0, 16'hFFFF);
         endcase
         write_regs(count, scale);
         for (int i = 0; i < items_per_phase; i++) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5:
                  send_item(MODE_LOAD, SLOT_BITS'($urandom_range(0, 3 * count - 1)),
                            rand_coord(), rand_coord(), rand_coord());
               6, 7, 8:
                  send_item(MODE_LOAD, SLOT_BITS'($urandom_range(0, 1023)),
                            rand_coord(), rand_coord(), rand_coord());
               9, 10, 11, 12, 13, 14, 15:
                  query_near_triangle($urandom_range(0, count - 1));
               default:
                  query_point(coord_type'($urandom), coord_type'($urandom),
                              coord_type'($urandom));
            endcase
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = MODE_LOAD;
      req_corner_slot = '0;
      req_coord_x     = '0;
      req_coord_y     = '0;
      req_coord_z     = '0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_TRI_COUNT;
      csr_wdata       = '0;
      cycle_count     = 0;
      error_count     = 0;
      load_items      = 0;
      query_items     = 0;
      hit_count       = 0;
      checked_count   = 0;
      long_hold_len   = 0;
      hold_count      = 0;
      stall_burst     = 0;
      idling_on       = 1'b1;
      tri_count_cfg   = '0;
      scale_cfg       = SCALE_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_store();
      test_directed_mesh();
      test_result_holdoff();
      test_random_phases(7, 80);
      // The last stretch runs without any idling on either side.
      idling_on = 1'b0;
      test_random_phases(1, 60);
      drain_results();
      repeat (50) @(posedge clock);

      $display("Covered %0d corner loads and %0d queries (%0d hits), %0d results checked.",
               load_items, query_items, hit_count, checked_count);
      $display("Scale ran from 0 to 65535 and walks from empty to the full mesh.");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
